[rtl/ffca_pkg.sv]
`default_nettype none
package ffca_pkg;

    localparam int MAX_BLOCKS = 64;
    localparam int MAX_FILES  = 16;
    localparam int BIDX_W     = $clog2(MAX_BLOCKS) + 1;
    localparam int BADDR_W    = $clog2(MAX_BLOCKS);
    localparam int FIDX_W     = $clog2(MAX_FILES) + 1;
    localparam int FADDR_W    = $clog2(MAX_FILES);

    localparam logic [8:0] OWNER_NONE = 9'd511;
    localparam logic [6:0] DISK_RESET = 7'd64;

    typedef enum logic [1:0] {
        REQ_CREATE  = 2'd0,
        REQ_DELETE  = 2'd1,
        REQ_PRELOAD = 2'd2,
        REQ_CLEAR   = 2'd3
    } req_t;

    typedef enum logic [3:0] {
        STS_OK        = 4'd0,
        STS_BAD_LEN   = 4'd1,
        STS_TOO_FEW   = 4'd2,
        STS_EXISTS    = 4'd3,
        STS_NO_RUN    = 4'd4,
        STS_NOT_FOUND = 4'd5,
        STS_NOT_PERM  = 4'd6,
        STS_FULL      = 4'd7,
        STS_BAD_PRE   = 4'd8
    } sts_t;

    typedef enum logic [1:0] {
        ACT_FAIL = 2'd0,
        ACT_RUN  = 2'd1,
        ACT_MARK = 2'd2,
        ACT_WIPE = 2'd3
    } act_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_DECIDE,
        ST_RUN,
        ST_MARK,
        ST_FIN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic cfg_write;
        logic load;
        logic lk_step;
        logic fail_dec;
        logic fail_run;
        logic wipe;
        logic run_clear;
        logic run_step;
        logic commit;
        logic mark_step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic lk_done;
        act_t act;
        logic run_done;
        logic run_found;
        logic mark_last;
    } stat_t;

    typedef struct packed {
        logic [15:0] name;
        logic [6:0]  start;
        logic [6:0]  length;
        logic [8:0]  owner;
    } entry_t;

endpackage
`default_nettype wire

[rtl/ffca_ctrl.sv]
`default_nettype none
module ffca_ctrl
    import ffca_pkg::*;
(
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    output logic        m_tvalid,
    input  wire         m_tready,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  stat_t       stat,
    output cmd_t        cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (!cfg_valid && s_tvalid) state_next = ST_LOOKUP;
            end
            ST_LOOKUP: begin
                if (stat.lk_done) state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                unique case (stat.act)
                    ACT_RUN:  state_next = ST_RUN;
                    ACT_MARK: state_next = ST_MARK;
                    default:  state_next = ST_OUT;
                endcase
            end
            ST_RUN: begin
                if (stat.run_done) state_next = stat.run_found ? ST_MARK : ST_OUT;
            end
            ST_MARK: begin
                if (stat.mark_last) state_next = ST_FIN;
            end
            ST_FIN:  state_next = ST_OUT;
            ST_OUT: begin
                if (m_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd       = '0;
        s_tready  = 1'b0;
        cfg_ready = 1'b0;
        m_tvalid  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                cfg_ready     = 1'b1;
                s_tready      = !cfg_valid;
                cmd.cfg_write = cfg_valid;
                cmd.load      = !cfg_valid && s_tvalid;
            end
            ST_LOOKUP: cmd.lk_step = !stat.lk_done;
            ST_DECIDE: begin
                unique case (stat.act)
                    ACT_FAIL: cmd.fail_dec  = 1'b1;
                    ACT_WIPE: cmd.wipe      = 1'b1;
                    ACT_RUN:  cmd.run_clear = 1'b1;
                    default:  cmd.commit    = 1'b1;
                endcase
            end
            ST_RUN: begin
                cmd.run_step = !stat.run_done;
                cmd.commit   = stat.run_done && stat.run_found;
                cmd.fail_run = stat.run_done && !stat.run_found;
            end
            ST_MARK: cmd.mark_step = 1'b1;
            ST_FIN:  cmd.finish    = 1'b1;
            ST_OUT:  m_tvalid      = 1'b1;
            default: ;
        endcase
    end

endmodule
`default_nettype wire

[rtl/ffca_dp.sv]
`default_nettype none
module ffca_dp
    import ffca_pkg::*;
(
    input  wire         aclk,
    input  wire         aresetn,
    input  wire  [1:0]  req_in,
    input  wire  [45:0] req_data,
    input  wire  [6:0]  cfg_data,
    input  cmd_t        cmd,
    output stat_t       stat,
    output logic [24:0] res_data
);

    logic [MAX_BLOCKS-1:0] used_reg;
    entry_t                tbl_reg [MAX_FILES];
    logic [FIDX_W-1:0]     n_reg;
    logic [6:0]            disk_reg;
    logic [6:0]            free_reg;

    req_t        req_reg;
    logic [7:0]  pid_reg;
    logic [15:0] key_reg;
    logic [6:0]  num_reg;
    logic [6:0]  sblk_reg;
    logic [7:0]  prio_reg;

    logic [FIDX_W-1:0] fidx_reg;
    logic              hit_reg;
    logic [BIDX_W-1:0] bidx_reg;
    logic [6:0]        run_reg;
    logic [6:0]        st_reg;
    logic              found_reg;
    logic [6:0]        mk_start_reg;
    logic [6:0]        mk_len_reg;
    logic              mk_val_reg;
    logic [6:0]        cnt_reg;
    logic [24:0]       res_reg;

    entry_t      cur;
    entry_t      hit_e;
    logic        full;
    sts_t        code;
    act_t        act;
    logic [7:0]  pre_end;
    logic [7:0]  mk_end;
    logic        in_range;
    logic        new_bit;
    logic [6:0]  cfg_clamped;
    logic        cur_used;

    assign cur      = tbl_reg[fidx_reg[FADDR_W-1:0]];
    assign hit_e    = cur;
    assign full     = (n_reg == FIDX_W'(MAX_FILES));
    assign pre_end  = {1'b0, sblk_reg} + {1'b0, num_reg};
    assign mk_end   = {1'b0, mk_start_reg} + {1'b0, mk_len_reg};
    assign cur_used = used_reg[bidx_reg[BADDR_W-1:0]];
    assign in_range = ({1'b0, bidx_reg} >= {1'b0, mk_start_reg})
                   && ({1'b0, bidx_reg} < mk_end);
    assign new_bit  = in_range ? mk_val_reg : cur_used;

    always_comb begin
        if (cfg_data == 7'd0) begin
            cfg_clamped = 7'd1;
        end else if (cfg_data > 7'(MAX_BLOCKS)) begin
            cfg_clamped = 7'(MAX_BLOCKS);
        end else begin
            cfg_clamped = cfg_data;
        end
    end

    always_comb begin
        act  = ACT_FAIL;
        code = STS_OK;
        case (req_reg)
            REQ_CREATE: begin
                if (num_reg == 7'd0)           code = STS_BAD_LEN;
                else if (num_reg > free_reg)   code = STS_TOO_FEW;
                else if (hit_reg)              code = STS_EXISTS;
                else if (full)                 code = STS_FULL;
                else                           act  = ACT_RUN;
            end
            REQ_DELETE: begin
                if (!hit_reg) begin
                    code = STS_NOT_FOUND;
                end else if (prio_reg != 8'd0 && hit_e.owner != {1'b0, pid_reg}) begin
                    code = STS_NOT_PERM;
                end else begin
                    act = ACT_MARK;
                end
            end
            REQ_PRELOAD: begin
                if (num_reg == 7'd0 || pre_end > {1'b0, disk_reg}) code = STS_BAD_PRE;
                else if (full)                                     code = STS_FULL;
                else                                               act  = ACT_MARK;
            end
            default: act = ACT_WIPE;
        endcase
    end

    assign stat.lk_done   = hit_reg || (fidx_reg == n_reg);
    assign stat.act       = act;
    assign stat.run_done  = found_reg || (bidx_reg == disk_reg);
    assign stat.run_found = found_reg;
    assign stat.mark_last = (bidx_reg == BIDX_W'(MAX_BLOCKS - 1));
    assign res_data       = res_reg;

    // request fields and scan registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg  <= req_t'(req_in);
            pid_reg  <= req_data[7:0];
            key_reg  <= req_data[23:8];
            num_reg  <= req_data[30:24];
            sblk_reg <= req_data[37:31];
            prio_reg <= req_data[45:38];
            fidx_reg <= '0;
            hit_reg  <= 1'b0;
        end
        if (cmd.lk_step) begin
            if (cur.name == key_reg) hit_reg <= 1'b1;
            else                     fidx_reg <= fidx_reg + 1'b1;
        end
        if (cmd.run_clear) begin
            bidx_reg  <= '0;
            run_reg   <= '0;
            found_reg <= 1'b0;
        end
        if (cmd.run_step) begin
            if (!cur_used) begin
                if (run_reg == 7'd0) st_reg <= bidx_reg;
                run_reg <= run_reg + 7'd1;
                if (run_reg + 7'd1 == num_reg) found_reg <= 1'b1;
            end else begin
                run_reg <= '0;
            end
            bidx_reg <= bidx_reg + 1'b1;
        end
        if (cmd.commit) begin
            bidx_reg <= '0;
            cnt_reg  <= '0;
            case (req_reg)
                REQ_CREATE: begin
                    mk_start_reg <= st_reg;
                    mk_len_reg   <= num_reg;
                    mk_val_reg   <= 1'b1;
                end
                REQ_PRELOAD: begin
                    mk_start_reg <= sblk_reg;
                    mk_len_reg   <= num_reg;
                    mk_val_reg   <= 1'b1;
                end
                default: begin
                    mk_start_reg <= hit_e.start;
                    mk_len_reg   <= hit_e.length;
                    mk_val_reg   <= 1'b0;
                end
            endcase
        end
        if (cmd.mark_step) begin
            bidx_reg <= bidx_reg + 1'b1;
            if (bidx_reg < disk_reg && !new_bit) cnt_reg <= cnt_reg + 7'd1;
        end
        if (cmd.fail_dec) res_reg <= {free_reg, 7'd0, 6'd0, code, 1'b0};
        if (cmd.fail_run) res_reg <= {free_reg, 7'd0, 6'd0, STS_NO_RUN, 1'b0};
        if (cmd.wipe)     res_reg <= {disk_reg, 7'd0, 6'd0, STS_OK, 1'b1};
        if (cmd.finish)   res_reg <= {cnt_reg, mk_len_reg, mk_start_reg[5:0], STS_OK, 1'b1};
    end

    // extent table, kept packed in slots below n_reg
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            case (req_reg)
                REQ_CREATE: tbl_reg[n_reg[FADDR_W-1:0]] <=
                    '{name: key_reg, start: st_reg, length: num_reg, owner: {1'b0, pid_reg}};
                REQ_PRELOAD: tbl_reg[n_reg[FADDR_W-1:0]] <=
                    '{name: key_reg, start: sblk_reg, length: num_reg, owner: OWNER_NONE};
                default: begin
                    for (int j = 0; j < MAX_FILES - 1; j++) begin
                        if (FIDX_W'(j) >= fidx_reg) tbl_reg[j] <= tbl_reg[j + 1];
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
            n_reg    <= '0;
            disk_reg <= DISK_RESET;
            free_reg <= DISK_RESET;
        end else begin
            if (cmd.cfg_write) begin
                used_reg <= '0;
                n_reg    <= '0;
                disk_reg <= cfg_clamped;
                free_reg <= cfg_clamped;
            end
            if (cmd.wipe) begin
                used_reg <= '0;
                n_reg    <= '0;
                free_reg <= disk_reg;
            end
            if (cmd.commit) begin
                if (req_reg == REQ_DELETE) n_reg <= n_reg - 1'b1;
                else                       n_reg <= n_reg + 1'b1;
            end
            if (cmd.mark_step) used_reg[bidx_reg[BADDR_W-1:0]] <= new_bit;
            if (cmd.finish)    free_reg <= cnt_reg;
        end
    end

endmodule
`default_nettype wire

[rtl/first_fit_contiguous_block_allocator.sv]
// create runs a table lookup, a first-fit run scan and the map pass; delete and preload run
// the lookup and the map pass; clear and failures end after the lookup or the run scan
// the block takes one request at a time; the next is accepted once the result transfer is done
// the map pass walks one block a cycle and recounts the free blocks on the way
// reset (aresetn low, synchronous) empties the map and table and sets 64 disk blocks
// a disk_blocks write also empties the map and table
`default_nettype none
module first_fit_contiguous_block_allocator
    import ffca_pkg::*;
(
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [47:0] s_tdata,  // pid, name_key, num_blocks, start_block, priority_req
    input  wire  [1:0]  s_tuser,  // req_type
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,  // ok, status, extent_start, extent_length, free_blocks
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [6:0]  cfg_data
);

    cmd_t        cmd;
    stat_t       stat;
    logic [24:0] res;

    ffca_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ffca_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req_in   (s_tuser),
        .req_data (s_tdata[45:0]),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .stat     (stat),
        .res_data (res)
    );

    assign m_tdata = {7'd0, res};

endmodule
`default_nettype wire
